/* rtl/awam_pkg.sv */
// Shared types and constants for the ADC window alarm monitor.
package awam_pkg;

    // Fixed field widths of the transaction payloads
    localparam int unsigned CHANNEL_FIELD_W = 4;
    localparam int unsigned VALUE_FIELD_W   = 12;
    localparam int unsigned VALUE_EXT_W     = 16;
    localparam int unsigned REF_W           = 16;
    localparam int unsigned VOLTAGE_W       = 16;
    localparam int unsigned MSG_W           = 17;
    localparam int unsigned MSG_ANY_BIT     = 16;

    localparam logic [REF_W-1:0] REF_RESET = 16'd1200;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_SAMPLE       = 2'd0,
        KIND_SET_LIMITS   = 2'd1,
        KIND_READ_VOLTAGE = 2'd2,
        KIND_READ_ALARMS  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic [CHANNEL_FIELD_W-1:0] channel;
        logic [VALUE_FIELD_W-1:0]   sample_value;
        logic [VALUE_FIELD_W-1:0]   upper_limit;
        logic [VALUE_FIELD_W-1:0]   lower_bound;
    } item_t;

    typedef struct packed {
        logic                 status;
        logic [VOLTAGE_W-1:0] voltage;
        logic [MSG_W-1:0]     alarm_message;
        logic                 irq;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic fetch;
        logic commit;
    } cmd_t;

endpackage

/* rtl/awam_ctrl.sv */
// Sequencing controller: accepts a transaction and steps it through fetch and commit.
module awam_ctrl
    import awam_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output logic done,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    // State and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_FETCH;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    // Datapath commands decoded from state and the start handshake
    always_comb
    begin
        cmd.load   = start && !busy_reg;
        cmd.fetch  = (state_reg == ST_FETCH);
        cmd.commit = (state_reg == ST_COMMIT);
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

/* rtl/awam_datapath.sv */
// Datapath: channel tables, alarm status, window compare and voltage scaling.
module awam_datapath
    import awam_pkg::*;
#(
    parameter int unsigned CHANNEL_COUNT      = 16,
    parameter int unsigned CHANNELS_PER_GROUP = 8,
    parameter int unsigned SAMPLE_BITS        = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  item_t            item,
    input  logic             cfg_we,
    input  logic [REF_W-1:0] cfg_data,
    output result_t          result
);

    localparam int unsigned GROUP_COUNT =
        (CHANNEL_COUNT + CHANNELS_PER_GROUP - 1) / CHANNELS_PER_GROUP;
    localparam int unsigned PROD_W = SAMPLE_BITS + REF_W;

    // Latched transaction and configuration
    item_t            item_reg;
    logic [REF_W-1:0] ref_reg;

    // Per-channel tables and per-group alarm state
    logic [SAMPLE_BITS-1:0]   upper_reg  [CHANNEL_COUNT];
    logic [SAMPLE_BITS-1:0]   upper_next [CHANNEL_COUNT];
    logic [SAMPLE_BITS-1:0]   lower_reg  [CHANNEL_COUNT];
    logic [SAMPLE_BITS-1:0]   lower_next [CHANNEL_COUNT];
    logic [SAMPLE_BITS-1:0]   sample_reg [CHANNEL_COUNT];
    logic [SAMPLE_BITS-1:0]   sample_next[CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] chan_alarm_reg;
    logic [CHANNEL_COUNT-1:0] chan_alarm_next;
    logic [GROUP_COUNT-1:0]   group_any_reg;
    logic [GROUP_COUNT-1:0]   group_any_next;
    logic [GROUP_COUNT-1:0]   armed_reg;
    logic [GROUP_COUNT-1:0]   armed_next;

    // Fetch stage
    logic [CHANNEL_COUNT-1:0] hit;
    logic [GROUP_COUNT-1:0]   grp_hit;
    logic [SAMPLE_BITS-1:0]   rd_upper;
    logic [SAMPLE_BITS-1:0]   rd_lower;
    logic [SAMPLE_BITS-1:0]   rd_sample;
    logic [CHANNEL_COUNT-1:0] hit_reg;
    logic [GROUP_COUNT-1:0]   grp_hit_reg;
    logic [SAMPLE_BITS-1:0]   rd_upper_reg;
    logic [SAMPLE_BITS-1:0]   rd_lower_reg;
    logic [SAMPLE_BITS-1:0]   rd_sample_reg;
    logic                     rd_armed_reg;

    // Commit stage
    logic [CHANNEL_COUNT-1:0] chan_grp_sel;
    logic [VALUE_EXT_W-1:0]   sample_ext;
    logic [VALUE_EXT_W-1:0]   upper_ext;
    logic [VALUE_EXT_W-1:0]   lower_ext;
    logic [SAMPLE_BITS-1:0]   new_sample;
    logic [SAMPLE_BITS-1:0]   new_upper;
    logic [SAMPLE_BITS-1:0]   new_lower;
    logic                     chan_valid;
    logic                     alarm;
    logic                     limits_bad;
    logic [PROD_W-1:0]        prod;
    result_t                  result_reg;
    result_t                  result_next;

    // One-hot channel decode; channels beyond the table never hit
    always_comb
    begin
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            hit[c] = (item_reg.channel == CHANNEL_FIELD_W'(c));
        end
    end

    // Group decode and group membership of every channel
    for (genvar g = 0; g < GROUP_COUNT; g++)
    begin : g_grp
        localparam int unsigned LO = g * CHANNELS_PER_GROUP;
        localparam int unsigned HI = (LO + CHANNELS_PER_GROUP < CHANNEL_COUNT) ?
                                     LO + CHANNELS_PER_GROUP : CHANNEL_COUNT;
        assign grp_hit[g] = |hit[HI-1:LO];
    end

    for (genvar c = 0; c < CHANNEL_COUNT; c++)
    begin : g_chan
        localparam int unsigned GRP = c / CHANNELS_PER_GROUP;
        assign chan_grp_sel[c] = grp_hit_reg[GRP];
    end

    // Table read through an and-or mux on the one-hot channel
    always_comb
    begin
        rd_upper  = '0;
        rd_lower  = '0;
        rd_sample = '0;
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            if (hit[c])
            begin
                rd_upper  = rd_upper | upper_reg[c];
                rd_lower  = rd_lower | lower_reg[c];
                rd_sample = rd_sample | sample_reg[c];
            end
        end
    end

    // Incoming values taken in their low SAMPLE_BITS bits
    always_comb
    begin
        sample_ext = VALUE_EXT_W'(item_reg.sample_value);
        upper_ext  = VALUE_EXT_W'(item_reg.upper_limit);
        lower_ext  = VALUE_EXT_W'(item_reg.lower_bound);
        new_sample = sample_ext[SAMPLE_BITS-1:0];
        new_upper  = upper_ext[SAMPLE_BITS-1:0];
        new_lower  = lower_ext[SAMPLE_BITS-1:0];
    end

    assign chan_valid = |hit_reg;
    assign alarm      = chan_valid && rd_armed_reg &&
                        ((new_sample > rd_upper_reg) || (new_sample < rd_lower_reg));
    assign limits_bad = !chan_valid || (new_upper <= new_lower);
    assign prod       = PROD_W'(rd_sample_reg) * PROD_W'(ref_reg);

    // Commit: state update and result for the transaction
    always_comb
    begin
        upper_next      = upper_reg;
        lower_next      = lower_reg;
        sample_next     = sample_reg;
        chan_alarm_next = chan_alarm_reg;
        group_any_next  = group_any_reg;
        armed_next      = armed_reg;
        result_next     = '0;
        case (item_reg.kind)
            KIND_SAMPLE:
            begin
                for (int c = 0; c < CHANNEL_COUNT; c++)
                begin
                    if (hit_reg[c])
                    begin
                        sample_next[c] = new_sample;
                    end
                end
                if (alarm)
                begin
                    chan_alarm_next = chan_alarm_reg | hit_reg;
                    group_any_next  = group_any_reg | grp_hit_reg;
                    armed_next      = armed_reg & ~grp_hit_reg;
                    result_next.irq = 1'b1;
                end
            end
            KIND_SET_LIMITS:
            begin
                if (limits_bad)
                begin
                    result_next.status = 1'b1;
                end
                else
                begin
                    for (int c = 0; c < CHANNEL_COUNT; c++)
                    begin
                        if (hit_reg[c])
                        begin
                            upper_next[c] = new_upper;
                            lower_next[c] = new_lower;
                        end
                    end
                    chan_alarm_next = chan_alarm_reg & ~chan_grp_sel;
                    group_any_next  = group_any_reg & ~grp_hit_reg;
                    armed_next      = armed_reg | grp_hit_reg;
                end
            end
            KIND_READ_VOLTAGE:
            begin
                // out-of-range channel reads a zero sample, so the product is zero
                result_next.voltage = prod[SAMPLE_BITS +: VOLTAGE_W];
            end
            KIND_READ_ALARMS:
            begin
                for (int c = 0; c < CHANNEL_COUNT; c++)
                begin
                    result_next.alarm_message[c] = chan_alarm_reg[c];
                end
                result_next.alarm_message[MSG_ANY_BIT] = |group_any_reg;
                chan_alarm_next = '0;
                group_any_next  = '0;
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    // Architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg        <= REF_RESET;
            chan_alarm_reg <= '0;
            group_any_reg  <= '0;
            armed_reg      <= '0;
            for (int c = 0; c < CHANNEL_COUNT; c++)
            begin
                upper_reg[c]  <= '1;
                lower_reg[c]  <= '0;
                sample_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                ref_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                upper_reg      <= upper_next;
                lower_reg      <= lower_next;
                sample_reg     <= sample_next;
                chan_alarm_reg <= chan_alarm_next;
                group_any_reg  <= group_any_next;
                armed_reg      <= armed_next;
            end
        end
    end

    // Payload pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.fetch)
        begin
            hit_reg       <= hit;
            grp_hit_reg   <= grp_hit;
            rd_upper_reg  <= rd_upper;
            rd_lower_reg  <= rd_lower;
            rd_sample_reg <= rd_sample;
            rd_armed_reg  <= |(grp_hit & armed_reg);
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

/* rtl/adc_window_alarm_monitor.sv */
// Top level of the ADC window alarm monitor: controller, datapath and checks.
//
// Usage:
//   Command channel: drive item and raise start; the transaction is taken at
//   a rising edge with start high and busy low. busy then stays high through
//   the table fetch and then the commit of state and result.
//   Result channel: done pulses for one cycle with result valid; the result
//   register holds its value until the next commit, but the receiver must
//   take it in the done cycle since it cannot hold results off.
//   Sequence: done is registered as the controller leaves commit, and no new
//   transaction is taken while busy; a new start may be taken in the same
//   cycle that done is shown. This pacing is set by the fetch/commit
//   sequence of the controller around the channel tables.
//   Configuration: cfg_data is written to the reference register at an edge
//   with cfg_valid and cfg_ready high; cfg_ready is high whenever idle and
//   start is low, so a write never overlaps a transaction.
//   Reset: limits open (upper all ones, lower zero), samples zero, alarm
//   status clear, both groups disarmed, reference 1200 mV.
module adc_window_alarm_monitor
    import awam_pkg::*;
#(
    parameter int unsigned CHANNEL_COUNT      = 16,
    parameter int unsigned CHANNELS_PER_GROUP = 8,
    parameter int unsigned SAMPLE_BITS        = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  item_t            item,
    output logic             done,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [REF_W-1:0] cfg_data
);

    cmd_t cmd;
    logic cfg_we;

    // Configuration write qualifier
    assign cfg_ready = !busy && !start;
    assign cfg_we    = cfg_valid && cfg_ready;

    awam_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    awam_datapath #(
        .CHANNEL_COUNT      (CHANNEL_COUNT),
        .CHANNELS_PER_GROUP (CHANNELS_PER_GROUP),
        .SAMPLE_BITS        (SAMPLE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .result   (result)
    );

    // Every accepted transaction is followed by its result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result strobe missing after accepted transaction");

    // Result strobe lasts one cycle and only while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && !cmd.fetch && !cmd.commit))
        else $error("result strobe while a transaction is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // Commit always follows a fetch of the same transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> $past(cmd.fetch))
        else $error("commit without preceding fetch");

endmodule

/* test/adc_window_alarm_monitor_tb.sv */
// Self-checking testbench for the ADC window alarm monitor: directed rows, then random traffic.
`timescale 1ns / 1ps

module adc_window_alarm_monitor_tb;
    import awam_pkg::*;

    localparam int CHANNELS       = 16;
    localparam int GROUP_SIZE     = 8;
    localparam int GROUPS         = 2;
    localparam int ANY_BIT        = 8;
    localparam int FULL_SCALE     = 4095;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_PRINTED    = 20;
    localparam int PHASE_ITEMS    = 138;

    typedef struct {
        item_t   it;
        bit      pin;
        result_t want;
    } dir_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    item_t            item;
    logic             done;
    result_t          result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [REF_W-1:0] cfg_data;

    // Typed expectation riding along with the item, for directed rows
    logic             pinned_on;
    result_t          pinned_res;

    // Shadow state of the monitor
    logic [11:0]      lim_upper [CHANNELS];
    logic [11:0]      lim_lower [CHANNELS];
    logic [11:0]      last_sample [CHANNELS];
    logic [8:0]       grp_status [GROUPS];
    logic             grp_armed [GROUPS];
    logic [REF_W-1:0] ref_mv;

    result_t          awaited_results [$];

    int               err_count = 0;
    int               n_results = 0;
    int               n_irq = 0;
    int               n_cfg = 0;
    int               kind_count [4] = '{0, 0, 0, 0};
    int               idle_count = 0;

    adc_window_alarm_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mismatch report: one line each, printing capped, all counted
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (err_count < MAX_PRINTED)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
                     got, want);
        err_count++;
    endtask

    // Shadow state after reset
    task automatic reset_window_state();
        for (int c = 0; c < CHANNELS; c++)
        begin
            lim_upper[c]   = 12'hFFF;
            lim_lower[c]   = 12'h000;
            last_sample[c] = 12'h000;
        end
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_status[g] = '0;
            grp_armed[g]  = 1'b0;
        end
        ref_mv = REF_RESET;
    endtask

    // One transaction through the window comparator, updating the shadow state
    task automatic alarm_monitor_step(input item_t it, output result_t r);
        int          ch;
        int          grp;
        int          pos;
        logic [27:0] prod;
        ch  = int'(it.channel);
        grp = ch / GROUP_SIZE;
        pos = ch % GROUP_SIZE;
        r   = '0;
        case (it.kind)
            KIND_SAMPLE:
            begin
                last_sample[ch] = it.sample_value;
                if (grp_armed[grp] &&
                    (it.sample_value > lim_upper[ch] || it.sample_value < lim_lower[ch]))
                begin
                    grp_status[grp][pos]     = 1'b1;
                    grp_status[grp][ANY_BIT] = 1'b1;
                    grp_armed[grp]           = 1'b0;
                    r.irq                    = 1'b1;
                end
            end
            KIND_SET_LIMITS:
            begin
                if (it.upper_limit <= it.lower_bound)
                    r.status = 1'b1;
                else
                begin
                    lim_upper[ch]   = it.upper_limit;
                    lim_lower[ch]   = it.lower_bound;
                    grp_status[grp] = '0;
                    grp_armed[grp]  = 1'b1;
                end
            end
            KIND_READ_VOLTAGE:
            begin
                prod      = last_sample[ch] * ref_mv;
                r.voltage = prod[27:12];
            end
            default:
            begin
                r.alarm_message[7:0]         = grp_status[0][7:0];
                r.alarm_message[15:8]        = grp_status[1][7:0];
                r.alarm_message[MSG_ANY_BIT] = grp_status[0][ANY_BIT] | grp_status[1][ANY_BIT];
                for (int g = 0; g < GROUPS; g++)
                    grp_status[g] = '0;
            end
        endcase
    endtask

    // Result checking, prediction on accept, register tracking
    always @(posedge clk)
    begin
        result_t want;
        result_t pred;
        if (rst_n)
        begin
            if (done)
            begin
                n_results++;
                if (awaited_results.size() == 0)
                    report_mismatch("result with nothing pending",
                                    32'(result.alarm_message), 0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", 32'(result.status), 32'(want.status));
                    if (result.voltage !== want.voltage)
                        report_mismatch("voltage", 32'(result.voltage), 32'(want.voltage));
                    if (result.alarm_message !== want.alarm_message)
                        report_mismatch("alarm_message", 32'(result.alarm_message),
                                        32'(want.alarm_message));
                    if (result.irq !== want.irq)
                        report_mismatch("irq", 32'(result.irq), 32'(want.irq));
                end
            end
            if (start && !busy)
            begin
                alarm_monitor_step(item, pred);
                kind_count[item.kind]++;
                if (pred.irq)
                    n_irq++;
                awaited_results.push_back(pinned_on ? pinned_res : pred);
            end
            if (cfg_valid && cfg_ready)
            begin
                ref_mv = cfg_data;
                n_cfg++;
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no transaction of any kind
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d quiet cycles", idle_count);
            $display("FAILED: results differ");
            $finish;
        end
        else
            idle_count <= idle_count + 1;
    end

    function automatic result_t mk_result(bit st, int v, int m, bit q);
        result_t r;
        r.status        = st;
        r.voltage       = v[15:0];
        r.alarm_message = m[16:0];
        r.irq           = q;
        return r;
    endfunction

    function automatic dir_row_t mk_row(kind_t k, int ch, int smp, int up, int lo, bit pin,
                                        result_t want);
        dir_row_t row;
        row.it.kind         = k;
        row.it.channel      = ch[3:0];
        row.it.sample_value = smp[11:0];
        row.it.upper_limit  = up[11:0];
        row.it.lower_bound  = lo[11:0];
        row.pin             = pin;
        row.want            = want;
        return row;
    endfunction

    // Random traffic, biased toward samples at the window edges
    function automatic item_t random_item();
        item_t it;
        int    pick;
        int    ch;
        int    v;
        int    lo;
        it.channel      = 4'($urandom_range(CHANNELS - 1));
        it.sample_value = 12'($urandom_range(FULL_SCALE));
        it.upper_limit  = 12'($urandom_range(FULL_SCALE));
        it.lower_bound  = 12'($urandom_range(FULL_SCALE));
        ch   = int'(it.channel);
        pick = $urandom_range(99);
        if (pick < 56)
        begin
            it.kind = KIND_SAMPLE;
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                v = int'($urandom_range(1) ? lim_upper[ch] : lim_lower[ch]);
                v = v + $urandom_range(4) - 2;
                if (v < 0)
                    v = 0;
                if (v > FULL_SCALE)
                    v = FULL_SCALE;
                it.sample_value = 12'(v);
            end
            else if (pick < 75)
                it.sample_value = 12'($urandom_range(1) ? FULL_SCALE : 0);
        end
        else if (pick < 78)
        begin
            it.kind = KIND_SET_LIMITS;
            pick = $urandom_range(99);
            if (pick < 10)
                it.upper_limit = it.lower_bound;
            else if (pick < 80)
            begin
                lo = $urandom_range(FULL_SCALE - 1);
                it.lower_bound = 12'(lo);
                if ($urandom_range(2) == 0)
                    v = lo + $urandom_range(8, 1);
                else
                    v = $urandom_range(FULL_SCALE, lo + 1);
                if (v > FULL_SCALE)
                    v = FULL_SCALE;
                it.upper_limit = 12'(v);
            end
            else if (pick < 85)
            begin
                it.lower_bound = '0;
                it.upper_limit = 12'(FULL_SCALE);
            end
        end
        else if (pick < 90)
            it.kind = KIND_READ_VOLTAGE;
        else
            it.kind = KIND_READ_ALARMS;
        return it;
    endfunction

    // Present one item and hold it until the block takes it; start stays high
    task automatic send_item(input item_t it, input bit pin, input result_t want);
        start      <= 1'b1;
        item       <= it;
        pinned_on  <= pin;
        pinned_res <= want;
        do
            @(posedge clk);
        while (!(start && !busy));
    endtask

    task automatic sender_gap(input int pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stop sending and wait for every pending result, then let the block settle
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reference(input logic [REF_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // Main sequence
    initial
    begin
        dir_row_t         dir_rows [$];
        int               idle_pct [4];
        logic [REF_W-1:0] phase_ref [4];
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        pinned_on  = 1'b0;
        pinned_res = '0;
        reset_window_state();

        // Sender idle per phase; the third phase stands for receiver stalls,
        // which this result port cannot apply
        idle_pct  = '{0, 76, 0, 15};
        phase_ref = '{16'hFFFF, 16'h0000, 16'($urandom_range(65535)),
                      16'($urandom_range(65535))};

        // Directed rows: reset state, window edges, rejected limits, alarm read-back
        dir_rows.push_back(mk_row(KIND_READ_ALARMS, 0, 0, 0, 0, 1, mk_result(0, 0, 0, 0)));
        dir_rows.push_back(mk_row(KIND_READ_VOLTAGE, 0, 0, 0, 0, 1, mk_result(0, 0, 0, 0)));
        dir_rows.push_back(mk_row(KIND_SAMPLE, 0, 4095, 0, 0, 1, mk_result(0, 0, 0, 0)));
        dir_rows.push_back(mk_row(KIND_READ_VOLTAGE, 0, 0, 0, 0, 1,
                                  mk_result(0, 1199, 0, 0)));
        dir_rows.push_back(mk_row(KIND_SET_LIMITS, 3, 0, 100, 100, 1, mk_result(1, 0, 0, 0)));
        dir_rows.push_back(mk_row(KIND_SET_LIMITS, 3, 0, 50, 100, 1, mk_result(1, 0, 0, 0)));
        dir_rows.push_back(mk_row(KIND_SET_LIMITS, 3, 0, 3000, 1000, 1,
                                  mk_result(0, 0, 0, 0)));
        dir_rows.push_back(mk_row(KIND_SAMPLE, 3, 3000, 0, 0, 1, mk_result(0, 0, 0, 0)));
        dir_rows.push_back(mk_row(KIND_SAMPLE, 3, 1000, 0, 0, 1, mk_result(0, 0, 0, 0)));
        dir_rows.push_back(mk_row(KIND_SAMPLE, 3, 3001, 0, 0, 1, mk_result(0, 0, 0, 1)));
        dir_rows.push_back(mk_row(KIND_SAMPLE, 3, 0, 0, 0, 1, mk_result(0, 0, 0, 0)));
        dir_rows.push_back(mk_row(KIND_READ_ALARMS, 0, 0, 0, 0, 1,
                                  mk_result(0, 0, 'h10008, 0)));
        dir_rows.push_back(mk_row(KIND_READ_ALARMS, 0, 0, 0, 0, 1, mk_result(0, 0, 0, 0)));
        dir_rows.push_back(mk_row(KIND_SET_LIMITS, 15, 0, 4095, 1, 0, '0));
        dir_rows.push_back(mk_row(KIND_SAMPLE, 15, 0, 0, 0, 1, mk_result(0, 0, 0, 1)));
        dir_rows.push_back(mk_row(KIND_SET_LIMITS, 8, 0, 1, 0, 0, '0));
        dir_rows.push_back(mk_row(KIND_SAMPLE, 8, 4095, 0, 0, 0, '0));
        dir_rows.push_back(mk_row(KIND_SET_LIMITS, 0, 0, 4095, 4094, 0, '0));
        dir_rows.push_back(mk_row(KIND_SAMPLE, 0, 4095, 0, 0, 0, '0));
        dir_rows.push_back(mk_row(KIND_READ_ALARMS, 0, 0, 0, 0, 0, '0));
        dir_rows.push_back(mk_row(KIND_SAMPLE, 15, 4095, 4095, 4095, 0, '0));
        dir_rows.push_back(mk_row(KIND_READ_VOLTAGE, 15, 4095, 4095, 4095, 0, '0));
        dir_rows.push_back(mk_row(KIND_SET_LIMITS, 7, 0, 0, 0, 1, mk_result(1, 0, 0, 0)));
        dir_rows.push_back(mk_row(KIND_READ_VOLTAGE, 8, 0, 0, 0, 0, '0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].pin, dir_rows[i].want);

        // Random phases, each under its own reference setting
        for (int p = 0; p < 4; p++)
        begin
            drain_results();
            write_reference(phase_ref[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(49) == 0)
                    drain_results();
                else
                    sender_gap(idle_pct[p]);
                send_item(random_item(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (awaited_results.size() != 0)
            report_mismatch("results never returned", awaited_results.size(), 0);

        $display("covered %0d samples, %0d limit writes, %0d voltage reads, %0d alarm reads",
                 kind_count[KIND_SAMPLE], kind_count[KIND_SET_LIMITS],
                 kind_count[KIND_READ_VOLTAGE], kind_count[KIND_READ_ALARMS]);
        $display("%0d results checked, %0d alarms latched, %0d reference writes",
                 n_results, n_irq, n_cfg);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
